// ===== sv/tfd_pkg.sv =====
// ============================================================================
// tfd_pkg
// Shared types and constants of the telemetry frame deframer.
// ============================================================================
package tfd_pkg;

    // Header bytes that open a frame.
    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'hAF;

    // Frame layout, as byte positions within the frame.
    localparam logic [5:0] POS_AFTER_SYNC    = 6'd2;
    localparam logic [5:0] LONG_WORDS_START  = 6'd4;
    localparam logic [5:0] SHORT_WORDS_START = 6'd16;
    localparam logic [5:0] SHORT_WORDS_END   = 6'd40;

    // Total frame length in bytes, header included (legal range 40 to 64).
    localparam logic [6:0] FRAME_BYTES = 7'd41;

    // Index of the final field of a frame.
    localparam logic [3:0] LAST_INDEX = 4'd14;

    // One decoded field.
    typedef struct packed {
        logic        last;
        logic [31:0] value;
        logic [3:0]  index;
    } field_t;

endpackage

// ===== sv/telemetry_frame_deframer.sv =====
// ============================================================================
// telemetry_frame_deframer
// Hunts for the 0xAA 0xAF header in a byte stream and emits one word per
// completed field of each 41-byte telemetry frame.
// ============================================================================
//
// Channel  Direction  Width  Contents
// s_       in         8      tdata[7:0] = rx_byte
// m_       out        40     tdata[3:0] = field_index, tdata[35:4] = field_value,
//                            tdata[39:36] = zero; tlast = last_field
//
// Each accepted byte is decoded in the same cycle it is taken, and any field
// it completes is loaded into the result register, so one byte per cycle is
// sustained. The result appears on m_ in the cycle after the completing byte.
// The input is stalled only while a result waits and m_tready is low.
// Reset (aresetn low, synchronous) returns the block to hunting for a header.
//
module telemetry_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [3:0] field_index, [35:4] field_value, [39:36] zero
    output logic        m_tlast     // last_field
);
    import tfd_pkg::*;

    logic   accept;
    logic   res_valid;
    field_t res;
    field_t out_field;

    // A new byte is taken whenever the result register is empty or is being
    // emptied in this same cycle.
    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    tfd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .rx_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    tfd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_field)
    );

    assign m_tdata = {4'd0, out_field.value, out_field.index};
    assign m_tlast = out_field.last;

    // The final-field mark goes with index 14 and nothing else.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[3:0] == LAST_INDEX)))
        else $error("last mark does not match field index");

    // No field index beyond the last one is ever produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= LAST_INDEX))
        else $error("field index out of range");

    // Short fields are sign extended from bit 15.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3:0] >= 4'd3) |->
            (m_tdata[35:20] == {16{m_tdata[19]}}))
        else $error("short field not sign extended");

    // A result is only produced by a byte that was actually accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> accept)
        else $error("result without an accepted byte");

endmodule

// ===== sv/tfd_parse.sv =====
// ============================================================================
// tfd_parse
// Header hunt and field assembly, one received byte per accepted word.
// ============================================================================
module tfd_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output tfd_pkg::field_t   res
);
    import tfd_pkg::*;

    logic        saw_sync_reg,   saw_sync_next;
    logic        in_frame_reg,   in_frame_next;
    logic [5:0]  pos_reg,        pos_next;
    logic [23:0] partial_reg,    partial_next;
    logic [3:0]  count_reg,      count_next;
    logic [6:0]  pos_inc;
    logic [15:0] short_word;

    assign pos_inc    = {1'b0, pos_reg} + 7'd1;
    assign short_word = {partial_reg[7:0], rx_byte};

    always_comb begin
        saw_sync_next = saw_sync_reg;
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        partial_next  = partial_reg;
        count_next    = count_reg;
        res_valid     = 1'b0;
        res.index     = count_reg;
        res.last      = (count_reg == LAST_INDEX);
        res.value     = {partial_reg, rx_byte};

        if (accept) begin
            if (!in_frame_reg) begin
                if (saw_sync_reg && rx_byte == SYNC_SECOND) begin
                    in_frame_next = 1'b1;
                    pos_next      = POS_AFTER_SYNC;
                    count_next    = '0;
                    partial_next  = '0;
                    saw_sync_next = 1'b0;
                end else begin
                    saw_sync_next = (rx_byte == SYNC_FIRST);
                end
            end else begin
                if (pos_reg >= LONG_WORDS_START && pos_reg < SHORT_WORDS_START) begin
                    // The long words start on a multiple of four, so the low
                    // position bits give the byte's place within its word.
                    if (pos_reg[1:0] != 2'd3) begin
                        partial_next = {partial_reg[15:0], rx_byte};
                    end else begin
                        res_valid    = 1'b1;
                        res.value    = {partial_reg, rx_byte};
                        partial_next = '0;
                        count_next   = count_reg + 4'd1;
                    end
                end else if (pos_reg >= SHORT_WORDS_START && pos_reg < SHORT_WORDS_END) begin
                    if (!pos_reg[0]) begin
                        partial_next = {16'd0, rx_byte};
                    end else begin
                        res_valid    = 1'b1;
                        res.value    = {{16{short_word[15]}}, short_word};
                        partial_next = '0;
                        count_next   = count_reg + 4'd1;
                    end
                end

                if (pos_inc >= FRAME_BYTES) begin
                    in_frame_next = 1'b0;
                    saw_sync_next = 1'b0;
                    pos_next      = '0;
                    partial_next  = '0;
                    count_next    = '0;
                end else begin
                    pos_next = pos_inc[5:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saw_sync_reg <= 1'b0;
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            partial_reg  <= '0;
            count_reg    <= '0;
        end else begin
            saw_sync_reg <= saw_sync_next;
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            partial_reg  <= partial_next;
            count_reg    <= count_next;
        end
    end

endmodule

// ===== sv/tfd_out_reg.sv =====
// ============================================================================
// tfd_out_reg
// Result register that holds a decoded field until the sink takes it.
// ============================================================================
module tfd_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tfd_pkg::field_t   load_data,
    input  logic              out_ready,
    output logic              out_valid,
    output tfd_pkg::field_t   out_data
);
    import tfd_pkg::*;

    logic   valid_reg;
    field_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
